// ===== design/bpa_pkg.sv =====
// Shared types, constants and helpers for the buddy page allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package bpa_pkg;

   localparam int TOP_RANK = 16;
   localparam int RANK_W = 5;
   localparam int PAGE_W = 16;
   localparam int LINK_W = PAGE_W + 1;
   localparam int POOL_PAGES_MAX = 1 << PAGE_W;
   localparam int HEAD_W = RANK_W + 1;

   // Empty list marker: one past the last page.
   localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_PAGES_MAX);

   // Request modes.
   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_RETURN = 2'd1;
   localparam logic [1:0] MODE_QRANK = 2'd2;
   localparam logic [1:0] MODE_QCOUNT = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NO_MEM = 2'd2;

   // Datapath operations.
   localparam logic [4:0] OP_NONE = 5'd0;
   localparam logic [4:0] OP_LOAD = 5'd1;
   localparam logic [4:0] OP_CLR_START = 5'd2;
   localparam logic [4:0] OP_CLR = 5'd3;
   localparam logic [4:0] OP_BUILD = 5'd4;
   localparam logic [4:0] OP_SEARCH = 5'd5;
   localparam logic [4:0] OP_TAKE = 5'd6;
   localparam logic [4:0] OP_UNLINK_RD = 5'd7;
   localparam logic [4:0] OP_UNLINK_WR = 5'd8;
   localparam logic [4:0] OP_SPLIT = 5'd9;
   localparam logic [4:0] OP_PUSH_A = 5'd10;
   localparam logic [4:0] OP_PUSH_B = 5'd11;
   localparam logic [4:0] OP_ALLOC_FIN = 5'd12;
   localparam logic [4:0] OP_RET_RD = 5'd13;
   localparam logic [4:0] OP_RET_CK = 5'd14;
   localparam logic [4:0] OP_BUD_RD = 5'd15;
   localparam logic [4:0] OP_BUD_TAKE = 5'd16;
   localparam logic [4:0] OP_MERGE = 5'd17;
   localparam logic [4:0] OP_Q_RD = 5'd18;
   localparam logic [4:0] OP_Q_HIT = 5'd19;
   localparam logic [4:0] OP_Q_NEXT = 5'd20;
   localparam logic [4:0] OP_COUNT = 5'd21;
   localparam logic [4:0] OP_NO_MEM = 5'd22;
   localparam logic [4:0] OP_EMIT = 5'd23;

   typedef struct packed {
      logic [4:0] op;
      logic       use_base;
   } cmd_type;

   typedef struct packed {
      logic       cfg_take;
      logic [1:0] mode;
      logic       rank_ok;
      logic       page_ok;
      logic       list_empty;
      logic       r_over;
      logic       r_above;
      logic       r_top;
      logic       ret_ok;
      logic       bud_in;
      logic       bud_match;
      logic       q_hit;
      logic       q_last;
      logic       build_more;
      logic       clr_last;
   } sts_type;

   // Number of pages covered by a block of rank r.
   function automatic logic [LINK_W-1:0] span(input logic [RANK_W-1:0] r);
      span = LINK_W'(1) << (r - RANK_W'(1));
   endfunction

endpackage

// ===== design/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== design/bpa_dp.sv =====
// Datapath of the buddy page allocator: pool register, free list heads and
// counts, block head and link memories, and the result registers. Uses bpa_pkg, bpa_ram.
module bpa_dp
   import bpa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [LINK_W-1:0]   csr_wdata,
   input  logic [1:0]          in_mode,
   input  logic [RANK_W-1:0]   in_rank,
   input  logic [PAGE_W-1:0]   in_page,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic [1:0]          out_status,
   output logic [PAGE_W-1:0]   out_page,
   output logic [LINK_W-1:0]   out_value
);

   logic [LINK_W-1:0] pool_ff;
   logic [LINK_W-1:0] list_head_ff [TOP_RANK+1];
   logic [LINK_W-1:0] free_cnt_ff [TOP_RANK+1];
   logic [1:0]        mode_ff;
   logic [RANK_W-1:0] rank_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [RANK_W-1:0] r_ff;
   logic [PAGE_W-1:0] base_ff;
   logic [PAGE_W-1:0] aux_ff;
   logic [LINK_W-1:0] hold_ff;
   logic [LINK_W-1:0] pos_ff;
   logic [PAGE_W-1:0] clr_ff;
   logic [1:0]        res_status_ff;
   logic [PAGE_W-1:0] res_page_ff;
   logic [LINK_W-1:0] res_value_ff;
   logic [1:0]        out_status_ff;
   logic [PAGE_W-1:0] out_page_ff;
   logic [LINK_W-1:0] out_value_ff;

   logic              head_we, next_we, prev_we;
   logic [PAGE_W-1:0] head_waddr, next_waddr, prev_waddr;
   logic [PAGE_W-1:0] head_raddr, link_raddr;
   logic [HEAD_W-1:0] head_wdata, head_rd;
   logic [LINK_W-1:0] next_wdata, prev_wdata, next_rd, prev_rd;

   logic [RANK_W-1:0] rsel;
   logic [RANK_W-1:0] csel;
   logic [LINK_W-1:0] cur_head;
   logic [PAGE_W-1:0] tgt;
   logic [PAGE_W-1:0] bud_c;
   logic [LINK_W-1:0] rem_c;
   logic [RANK_W-1:0] build_r;
   logic [RANK_W-1:0] msb_c;
   logic [PAGE_W-1:0] align_mask;
   logic              cfg_take;
   logic [LINK_W-1:0] span_r;
   logic [LINK_W-1:0] span_dn;
   logic [LINK_W-1:0] build_span;
   logic [LINK_W-1:0] build_link;

   assign cfg_take = csr_we && (csr_wdata != '0) && (csr_wdata <= LINK_W'(POOL_PAGES_MAX));

   // Rank selects kept inside the list arrays.
   assign rsel = (r_ff > RANK_W'(TOP_RANK)) ? '0 : r_ff;
   assign csel = (rank_ff > RANK_W'(TOP_RANK)) ? '0 : rank_ff;
   assign cur_head = list_head_ff[rsel];
   assign tgt = cmd.use_base ? base_ff : aux_ff;
   assign span_r = span(r_ff);
   assign span_dn = span(r_ff - RANK_W'(1));
   assign bud_c = base_ff ^ span_r[PAGE_W-1:0];
   assign align_mask = {PAGE_W{1'b1}} << (r_ff - RANK_W'(1));

   // Largest block that fits in what is left of the pool.
   assign rem_c = pool_ff - pos_ff;
   always_comb begin
      msb_c = '0;
      for (int i = 0; i < LINK_W; i++) begin
         if (rem_c[i]) begin
            msb_c = RANK_W'(i);
         end
      end
   end
   assign build_r = (msb_c >= RANK_W'(TOP_RANK)) ? RANK_W'(TOP_RANK) : msb_c + RANK_W'(1);
   assign build_span = span(build_r);

   // Only the top rank can hold several initial blocks; each one that is
   // followed by another gets that one as its list predecessor.
   assign build_link = (build_r == RANK_W'(TOP_RANK) && (rem_c - build_span) >= build_span) ?
                       pos_ff + build_span : NIL;

   // Status toward the controller.
   always_comb begin
      sts.cfg_take = cfg_take;
      sts.mode = mode_ff;
      sts.rank_ok = (rank_ff != '0) && (rank_ff <= RANK_W'(TOP_RANK));
      sts.page_ok = {1'b0, page_ff} < pool_ff;
      sts.list_empty = cur_head[PAGE_W];
      sts.r_over = r_ff > RANK_W'(TOP_RANK);
      sts.r_above = r_ff > rank_ff;
      sts.r_top = r_ff >= RANK_W'(TOP_RANK);
      sts.ret_ok = head_rd[RANK_W];
      sts.bud_in = {1'b0, bud_c} < pool_ff;
      sts.bud_match = !head_rd[RANK_W] && (head_rd[RANK_W-1:0] == r_ff);
      sts.q_hit = (!head_rd[RANK_W] && (head_rd[RANK_W-1:0] == r_ff)) ||
                  (head_rd[RANK_W] && (r_ff == RANK_W'(1)));
      sts.q_last = r_ff >= RANK_W'(TOP_RANK);
      sts.build_more = pos_ff < pool_ff;
      sts.clr_last = clr_ff == {PAGE_W{1'b1}};
   end

   // Memory port steering.
   always_comb begin
      head_we = 1'b0;
      head_waddr = tgt;
      head_wdata = '0;
      next_we = 1'b0;
      next_waddr = tgt;
      next_wdata = NIL;
      prev_we = 1'b0;
      prev_waddr = tgt;
      prev_wdata = NIL;
      head_raddr = page_ff;
      link_raddr = tgt;
      case (cmd.op)
         OP_CLR: begin
            head_we = 1'b1;
            head_waddr = clr_ff;
         end
         OP_BUILD: begin
            head_we = 1'b1;
            head_waddr = pos_ff[PAGE_W-1:0];
            head_wdata = {1'b0, build_r};
            next_we = 1'b1;
            next_waddr = pos_ff[PAGE_W-1:0];
            next_wdata = list_head_ff[build_r];
            prev_we = 1'b1;
            prev_waddr = pos_ff[PAGE_W-1:0];
            prev_wdata = build_link;
         end
         OP_UNLINK_WR: begin
            next_we = !prev_rd[PAGE_W];
            next_waddr = prev_rd[PAGE_W-1:0];
            next_wdata = next_rd;
            prev_we = !next_rd[PAGE_W];
            prev_waddr = next_rd[PAGE_W-1:0];
            prev_wdata = prev_rd;
         end
         OP_PUSH_A: begin
            head_we = 1'b1;
            head_wdata = {1'b0, r_ff};
            next_we = 1'b1;
            next_wdata = cur_head;
            prev_we = 1'b1;
         end
         OP_PUSH_B: begin
            prev_we = !hold_ff[PAGE_W];
            prev_waddr = hold_ff[PAGE_W-1:0];
            prev_wdata = {1'b0, tgt};
         end
         OP_ALLOC_FIN: begin
            head_we = 1'b1;
            head_waddr = base_ff;
            head_wdata = {1'b1, rank_ff};
         end
         OP_RET_CK: begin
            head_we = 1'b1;
            head_waddr = page_ff;
         end
         OP_BUD_RD: begin
            head_raddr = bud_c;
         end
         OP_BUD_TAKE: begin
            head_we = 1'b1;
            head_waddr = aux_ff;
         end
         OP_Q_RD: begin
            head_raddr = page_ff & align_mask;
         end
         default: begin
         end
      endcase
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= LINK_W'(POOL_PAGES_MAX);
      end else if (cfg_take) begin
         pool_ff <= csr_wdata;
      end
   end

   // Working registers, list heads and counts, results.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            mode_ff <= in_mode;
            rank_ff <= in_rank;
            page_ff <= in_page;
            r_ff <= (in_mode == MODE_QRANK) ? RANK_W'(1) : in_rank;
            res_status_ff <= ST_INVALID;
            res_page_ff <= '0;
            res_value_ff <= '0;
         end
         OP_CLR_START: begin
            for (int i = 0; i <= TOP_RANK; i++) begin
               list_head_ff[i] <= NIL;
               free_cnt_ff[i] <= '0;
            end
            clr_ff <= '0;
            pos_ff <= '0;
         end
         OP_CLR: begin
            clr_ff <= clr_ff + PAGE_W'(1);
         end
         OP_BUILD: begin
            list_head_ff[build_r] <= pos_ff;
            free_cnt_ff[build_r] <= free_cnt_ff[build_r] + LINK_W'(1);
            pos_ff <= pos_ff + build_span;
         end
         OP_SEARCH: begin
            r_ff <= r_ff + RANK_W'(1);
         end
         OP_TAKE: begin
            base_ff <= cur_head[PAGE_W-1:0];
         end
         OP_UNLINK_WR: begin
            if (prev_rd[PAGE_W]) begin
               list_head_ff[rsel] <= next_rd;
            end
            free_cnt_ff[rsel] <= free_cnt_ff[rsel] - LINK_W'(1);
         end
         OP_SPLIT: begin
            r_ff <= r_ff - RANK_W'(1);
            aux_ff <= base_ff + span_dn[PAGE_W-1:0];
         end
         OP_PUSH_A: begin
            hold_ff <= cur_head;
            list_head_ff[rsel] <= {1'b0, tgt};
            free_cnt_ff[rsel] <= free_cnt_ff[rsel] + LINK_W'(1);
         end
         OP_ALLOC_FIN: begin
            res_status_ff <= ST_OK;
            res_page_ff <= base_ff;
         end
         OP_RET_CK: begin
            base_ff <= page_ff;
            r_ff <= head_rd[RANK_W-1:0];
            res_status_ff <= ST_OK;
         end
         OP_BUD_RD: begin
            aux_ff <= bud_c;
         end
         OP_MERGE: begin
            if (aux_ff < base_ff) begin
               base_ff <= aux_ff;
            end
            r_ff <= r_ff + RANK_W'(1);
         end
         OP_Q_HIT: begin
            res_status_ff <= ST_OK;
            res_value_ff <= LINK_W'(head_rd[RANK_W-1:0]);
         end
         OP_Q_NEXT: begin
            r_ff <= r_ff + RANK_W'(1);
         end
         OP_COUNT: begin
            res_status_ff <= ST_OK;
            res_value_ff <= free_cnt_ff[csel];
         end
         OP_NO_MEM: begin
            res_status_ff <= ST_NO_MEM;
         end
         OP_EMIT: begin
            out_status_ff <= res_status_ff;
            out_page_ff <= res_page_ff;
            out_value_ff <= res_value_ff;
         end
         default: begin
         end
      endcase
   end

   assign out_status = out_status_ff;
   assign out_page = out_page_ff;
   assign out_value = out_value_ff;

   // Block head marks: bit RANK_W set for an allocated head, else a free head or zero.
   bpa_ram #(.WIDTH(HEAD_W), .DEPTH(POOL_PAGES_MAX)) u_head_mem (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rd)
   );

   // Forward links of the free lists.
   bpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES_MAX)) u_next_mem (
      .clock(clock), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
      .raddr(link_raddr), .rdata(next_rd)
   );

   // Backward links of the free lists.
   bpa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_PAGES_MAX)) u_prev_mem (
      .clock(clock), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
      .raddr(link_raddr), .rdata(prev_rd)
   );

endmodule

// ===== design/bpa_ctrl.sv =====
// Controller of the buddy page allocator: sequences clearing, pool build and
// each request through the datapath, and owns the handshakes. Uses bpa_pkg.
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [4:0] S_CLR0 = 5'd0;
   localparam logic [4:0] S_CLR = 5'd1;
   localparam logic [4:0] S_BUILD = 5'd2;
   localparam logic [4:0] S_IDLE = 5'd3;
   localparam logic [4:0] S_DISP = 5'd4;
   localparam logic [4:0] S_SEARCH = 5'd5;
   localparam logic [4:0] S_URD_A = 5'd6;
   localparam logic [4:0] S_UWR_A = 5'd7;
   localparam logic [4:0] S_SPLIT = 5'd8;
   localparam logic [4:0] S_PUSHA_A = 5'd9;
   localparam logic [4:0] S_PUSHB_A = 5'd10;
   localparam logic [4:0] S_RET_CK = 5'd11;
   localparam logic [4:0] S_MERGE = 5'd12;
   localparam logic [4:0] S_BUD_CK = 5'd13;
   localparam logic [4:0] S_UWR_R = 5'd14;
   localparam logic [4:0] S_MERGE_UP = 5'd15;
   localparam logic [4:0] S_PUSHB_R = 5'd16;
   localparam logic [4:0] S_QRD = 5'd17;
   localparam logic [4:0] S_QCK = 5'd18;
   localparam logic [4:0] S_FIN = 5'd19;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath command.
   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      cmd.use_base = 1'b1;
      case (state_ff)
         S_CLR0: begin
            cmd.op = OP_CLR_START;
            state_in = S_CLR;
         end
         S_CLR: begin
            cmd.op = OP_CLR;
            if (sts.clr_last) state_in = S_BUILD;
         end
         S_BUILD: begin
            if (sts.build_more) cmd.op = OP_BUILD;
            else state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_FIN;
            case (sts.mode)
               MODE_ALLOC: if (sts.rank_ok) state_in = S_SEARCH;
               MODE_RETURN: begin
                  if (sts.page_ok) begin
                     cmd.op = OP_RET_RD;
                     state_in = S_RET_CK;
                  end
               end
               MODE_QRANK: if (sts.page_ok) state_in = S_QRD;
               default: if (sts.rank_ok) cmd.op = OP_COUNT;
            endcase
         end
         S_SEARCH: begin
            if (sts.r_over) begin
               cmd.op = OP_NO_MEM;
               state_in = S_FIN;
            end else if (sts.list_empty) begin
               cmd.op = OP_SEARCH;
            end else begin
               cmd.op = OP_TAKE;
               state_in = S_URD_A;
            end
         end
         S_URD_A: begin
            cmd.op = OP_UNLINK_RD;
            state_in = S_UWR_A;
         end
         S_UWR_A: begin
            cmd.op = OP_UNLINK_WR;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (sts.r_above) begin
               cmd.op = OP_SPLIT;
               state_in = S_PUSHA_A;
            end else begin
               cmd.op = OP_ALLOC_FIN;
               state_in = S_FIN;
            end
         end
         S_PUSHA_A: begin
            cmd.op = OP_PUSH_A;
            cmd.use_base = 1'b0;
            state_in = S_PUSHB_A;
         end
         S_PUSHB_A: begin
            cmd.op = OP_PUSH_B;
            cmd.use_base = 1'b0;
            state_in = S_SPLIT;
         end
         S_RET_CK: begin
            if (sts.ret_ok) begin
               cmd.op = OP_RET_CK;
               state_in = S_MERGE;
            end else begin
               state_in = S_FIN;
            end
         end
         S_MERGE: begin
            if (!sts.r_top && sts.bud_in) begin
               cmd.op = OP_BUD_RD;
               state_in = S_BUD_CK;
            end else begin
               cmd.op = OP_PUSH_A;
               state_in = S_PUSHB_R;
            end
         end
         S_BUD_CK: begin
            if (sts.bud_match) begin
               cmd.op = OP_BUD_TAKE;
               cmd.use_base = 1'b0;
               state_in = S_UWR_R;
            end else begin
               cmd.op = OP_PUSH_A;
               state_in = S_PUSHB_R;
            end
         end
         S_UWR_R: begin
            cmd.op = OP_UNLINK_WR;
            cmd.use_base = 1'b0;
            state_in = S_MERGE_UP;
         end
         S_MERGE_UP: begin
            cmd.op = OP_MERGE;
            state_in = S_MERGE;
         end
         S_PUSHB_R: begin
            cmd.op = OP_PUSH_B;
            state_in = S_FIN;
         end
         S_QRD: begin
            cmd.op = OP_Q_RD;
            state_in = S_QCK;
         end
         S_QCK: begin
            if (sts.q_hit) begin
               cmd.op = OP_Q_HIT;
               state_in = S_FIN;
            end else if (sts.q_last) begin
               state_in = S_FIN;
            end else begin
               cmd.op = OP_Q_NEXT;
               state_in = S_QRD;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.op = OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR0;
         end
      endcase
      // A valid pool write restarts the rebuild.
      if (sts.cfg_take) begin
         state_in = S_CLR0;
      end
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_FIN && out_free) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // A valid pool write always restarts the clearing pass.
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      sts.cfg_take |=> state_ff == S_CLR0) else $error("pool write did not restart");

   // A finished result waits while the output register is still full.
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !out_free && !sts.cfg_take) |=> state_ff == S_FIN)
      else $error("result dropped while output busy");

   // A result only appears from the finishing step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result raised outside finish");
`endif

endmodule

// ===== design/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: stream ports, controller and datapath.
// Uses bpa_pkg, bpa_ctrl, bpa_dp.
//
//   channel   direction  transfer when           payload
//   req_      in         req_tvalid & tready    tuser: mode; tdata: req_rank, page_index
//   rsp_      out        rsp_tvalid & tready    tuser: status; tdata: alloc_page, value
//   csr_      in         csr_we                 csr_wdata: pool_pages
//
// Allocate searches upward one rank at a time, then splits the block it takes.
// Return merges with each free buddy in turn, each merge a head memory read and
// a link read-modify-write. Rank query checks one rank at a time; count reads a register.
// Reset and each valid pool write start a clearing pass over the whole head memory,
// then write the initial blocks; no request is taken meanwhile.
// A result waiting on rsp_tready does not block the next request transfer.
module buddy_page_allocator
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [4:0] req_rank, [20:5] page_index
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [15:0] alloc_page, [32:16] value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic [16:0] csr_wdata    // pool_pages
);

   cmd_type           cmd;
   sts_type           sts;
   logic [PAGE_W-1:0] out_page;
   logic [LINK_W-1:0] out_value;

   // Sequencer.
   bpa_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   // Lists, memories and result registers.
   bpa_dp u_dp (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .in_mode(req_tuser), .in_rank(req_tdata[4:0]), .in_page(req_tdata[20:5]),
      .cmd(cmd), .sts(sts),
      .out_status(rsp_tuser), .out_page(out_page), .out_value(out_value)
   );

   assign rsp_tdata = {7'd0, out_value, out_page};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the buddy page allocator.
// Depends on bpa_pkg and buddy_page_allocator; a shadow allocator predicts every response.

class alloc_scoreboard;
   int unsigned pool_size;
   bit [16:0]   head_of_rank[17];
   bit [16:0]   count_of_rank[17];
   bit [16:0]   fwd[int];
   bit [16:0]   bwd[int];
   bit [4:0]    free_rank[int];
   bit [4:0]    used_rank[int];
   bit [1:0]    want_status[$];
   bit [15:0]   want_page[$];
   bit [16:0]   want_value[$];
   int          errors;
   int          checked;

   function int unsigned pages_of(int unsigned r);
      return 1 << (r - 1);
   endfunction

   function bit [4:0] frank(int unsigned p);
      return free_rank.exists(p) ? free_rank[p] : 5'd0;
   endfunction

   function void paint(int unsigned start, int unsigned n, bit [4:0] r);
      for (int unsigned i = start; i < start + n; i++) begin
         if (r == 0) free_rank.delete(i);
         else free_rank[i] = r;
      end
   endfunction

   function void push_free(int unsigned r, int unsigned b);
      bit [16:0] h;
      h = head_of_rank[r];
      bwd[b] = bpa_pkg::NIL;
      fwd[b] = h;
      if (h < bpa_pkg::NIL) bwd[h] = b;
      head_of_rank[r] = b;
      count_of_rank[r]++;
   endfunction

   function void drop_free(int unsigned r, int unsigned b);
      bit [16:0] p;
      bit [16:0] n;
      p = bwd[b];
      n = fwd[b];
      if (p < bpa_pkg::NIL) fwd[p] = n;
      else head_of_rank[r] = n;
      if (n < bpa_pkg::NIL) bwd[n] = p;
      count_of_rank[r]--;
   endfunction

   // Carve the pool into the largest aligned blocks, all free.
   function void carve(int unsigned pages);
      int unsigned pos;
      int unsigned r;
      pos = 0;
      if (pages == 0 || pages > bpa_pkg::POOL_PAGES_MAX) return;
      pool_size = pages;
      for (int i = 0; i <= 16; i++) begin
         head_of_rank[i] = bpa_pkg::NIL;
         count_of_rank[i] = 0;
      end
      fwd.delete(); bwd.delete(); free_rank.delete(); used_rank.delete();
      while (pos < pool_size) begin
         r = 16;
         while (r > 1 && pos + pages_of(r) > pool_size) r--;
         push_free(r, pos);
         paint(pos, pages_of(r), r);
         pos += pages_of(r);
      end
   endfunction

   // Note an accepted request and queue its expected response.
   function void note_request(bit [1:0] mode, bit [4:0] rank, bit [15:0] pg_in);
      bit [1:0]    st;
      bit [15:0]   pg_out;
      bit [16:0]   val;
      int unsigned found, start, r, bud, pg;
      st = bpa_pkg::ST_INVALID; pg_out = 0; val = 0; pg = pg_in;
      case (mode)
         bpa_pkg::MODE_ALLOC: if (rank >= 1 && rank <= 16) begin
            found = rank;
            while (found <= 16 && head_of_rank[found] >= bpa_pkg::NIL) found++;
            if (found > 16) st = bpa_pkg::ST_NO_MEM;
            else begin
               start = head_of_rank[found];
               drop_free(found, start);
               while (found > rank) begin
                  found--;
                  push_free(found, start + pages_of(found));
                  paint(start + pages_of(found), pages_of(found), found);
               end
               paint(start, pages_of(rank), 0);
               used_rank[start] = rank;
               st = bpa_pkg::ST_OK;
               pg_out = start;
            end
         end
         bpa_pkg::MODE_RETURN:
            if (pg < pool_size && frank(pg) == 0 && used_rank.exists(pg)) begin
               r = used_rank[pg];
               used_rank.delete(pg);
               while (r < 16) begin
                  bud = pg ^ pages_of(r);
                  if (bud >= pool_size || frank(bud) != r) break;
                  drop_free(r, bud);
                  paint(bud, pages_of(r), 0);
                  if (bud < pg) pg = bud;
                  r++;
               end
               push_free(r, pg);
               paint(pg, pages_of(r), r);
               st = bpa_pkg::ST_OK;
            end
         bpa_pkg::MODE_QRANK: if (pg < pool_size) begin
            if (frank(pg) != 0) begin
               st = bpa_pkg::ST_OK; val = frank(pg);
            end else if (used_rank.exists(pg)) begin
               st = bpa_pkg::ST_OK; val = used_rank[pg];
            end
         end
         default: if (rank >= 1 && rank <= 16) begin
            st = bpa_pkg::ST_OK; val = count_of_rank[rank];
         end
      endcase
      want_status.push_back(st);
      want_page.push_back(pg_out);
      want_value.push_back(val);
   endfunction

   function void check_response(bit [1:0] st, bit [15:0] pg, bit [16:0] val);
      bit [1:0]  es;
      bit [15:0] ep;
      bit [16:0] ev;
      if (want_status.size() == 0) begin
         $error("response with nothing expected: status %0d", st);
         errors++;
         return;
      end
      es = want_status.pop_front(); ep = want_page.pop_front(); ev = want_value.pop_front();
      checked++;
      if (st != es) begin $error("status: expected %0d, got %0d", es, st); errors++; end
      if (pg != ep) begin $error("alloc_page: expected %0d, got %0d", ep, pg); errors++; end
      if (val != ev) begin $error("value: expected %0d, got %0d", ev, val); errors++; end
   endfunction
endclass

module tb_top;
   import bpa_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic [1:0]  req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [16:0] csr_wdata = 0;

   alloc_scoreboard board = new();
   bit          steady;       // no idling on either side
   bit          hold_rsp;     // long receiver hold-off
   int          n_sent;
   bit [15:0]   live_pages[$];

   always #5 clock = ~clock;

   buddy_page_allocator dut (.*);

   // Response side: random stalls, sampled at the rising edge.
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 34);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tuser, rsp_tdata[15:0], rsp_tdata[32:16]);
   end

   // One request transfer; the model is updated at the accepting edge.
   // Starts and ends at a falling edge; valid stays high until the next
   // request or an explicit idle drops it.
   task automatic send_request(input bit [1:0] mode, input bit [4:0] rank,
                               input bit [15:0] pg);
      if (!steady)
         while ($urandom_range(99) < 34) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {3'b0, pg, rank};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(mode, rank, pg);
      if (mode == MODE_ALLOC && board.want_status[$] == ST_OK)
         live_pages.push_back(board.want_page[$]);
      n_sent++;
      @(negedge clock);
   endtask

   // Wait until all expected responses are in, then write the pool size and rebuild the model.
   task automatic write_pool(input bit [16:0] pages);
      req_tvalid <= 1'b0;
      while (board.want_status.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= pages;
      @(negedge clock);
      csr_we <= 1'b0;
      board.carve(pages);
      live_pages.delete();
   endtask

   task automatic random_phase(input int count, input int unsigned pages);
      int unsigned pick;
      bit [15:0]   pg;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_request(MODE_ALLOC, 5'($urandom_range(pages > 64 ? 4 : 3, 1)), 16'd0);
         else if (pick < 70 && live_pages.size() != 0) begin
            pick = $urandom_range(live_pages.size() - 1);
            pg = live_pages[pick];
            live_pages.delete(pick);
            send_request(MODE_RETURN, 5'd0, pg);
         end else if (pick < 82)
            send_request(MODE_QRANK, 5'd0, 16'($urandom_range(pages + 2, 0)));
         else if (pick < 92)
            send_request(MODE_QCOUNT, 5'($urandom_range(17, 0)), 16'd0);
         else
            send_request(2'($urandom), 5'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      #60000000;
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      board.carve(POOL_PAGES_MAX);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full pool, extremes and every mode.
      send_request(MODE_QCOUNT, 16, 0);
      send_request(MODE_QCOUNT, 0, 0);
      send_request(MODE_QCOUNT, 31, 0);
      send_request(MODE_ALLOC, 0, 16'hFFFF);
      send_request(MODE_ALLOC, 17, 0);
      send_request(MODE_ALLOC, 1, 0);
      send_request(MODE_QRANK, 0, 0);
      send_request(MODE_QRANK, 0, 16'hFFFF);
      send_request(MODE_QRANK, 0, 16'h8000);
      send_request(MODE_RETURN, 0, 1);
      send_request(MODE_RETURN, 0, 16'h8000);
      send_request(MODE_RETURN, 0, 0);
      send_request(MODE_RETURN, 0, 0);
      send_request(MODE_ALLOC, 16, 0);
      send_request(MODE_ALLOC, 16, 0);
      send_request(MODE_ALLOC, 1, 0);
      send_request(MODE_RETURN, 0, 0);
      send_request(MODE_ALLOC, 31, 16'h5555);

      // Small odd pool: page outside the pool, exhaustion.
      write_pool(17'd5);
      send_request(MODE_QRANK, 0, 5);
      send_request(MODE_QRANK, 0, 4);
      send_request(MODE_ALLOC, 3, 0);
      send_request(MODE_ALLOC, 3, 0);
      send_request(MODE_RETURN, 0, 5);
      write_pool(17'd0);
      write_pool(17'h1FFFF);

      write_pool(17'd1);
      random_phase(60, 1);
      write_pool(17'd37);
      random_phase(250, 37);

      // Hold-off: the receiver stops while requests keep coming.
      steady = 1;
      fork
         begin
            hold_rsp = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         random_phase(40, 37);
      join
      steady = 0;

      write_pool(17'd200);
      random_phase(300, 200);
      write_pool(17'd65536);
      random_phase(200, 65536);

      req_tvalid <= 1'b0;
      while (board.want_status.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Covered %0d requests and %0d checked responses over pools of 1 to 65536 pages,",
               n_sent, board.checked);
      $display("with all four modes, invalid fields, exhaustion and a long response stall.");
      if (board.errors == 0 && board.want_status.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_dp.sv
design/bpa_ctrl.sv
design/buddy_page_allocator.sv
tb/tb_top.sv
